// File: hdl/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// Types, constants and saturation helpers for the spatial vector transform.
// ----------------------------------------------------------------------------
package svt_pkg;

   localparam int VEC_FRAC_BITS = 16;
   localparam int ROT_FRAC_BITS = 16;

   localparam int VEC_W       = 32;
   localparam int MID_W       = 40;
   localparam int ROT_ENTRY_W = 18;
   localparam int ROT_ROW_W   = 3 * ROT_ENTRY_W;

   // First rotation: entry times a 33-bit operand (a, or point minus translation)
   localparam int X1_W = VEC_W + 1;
   localparam int P1_W = ROT_ENTRY_W + X1_W;
   localparam int S1_W = P1_W + 2;
   localparam int Y1_W = S1_W - ROT_FRAC_BITS;

   // Cross product with the translation
   localparam int XP_W = 2 * VEC_W;
   localparam int XD_W = XP_W + 1;
   localparam int C_W  = XD_W - VEC_FRAC_BITS;

   // Second rotation: entry times a 40-bit operand
   localparam int P2_W = ROT_ENTRY_W + MID_W;
   localparam int S2_W = P2_W + 2;
   localparam int Y2_W = S2_W - ROT_FRAC_BITS;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = ROT_ROW_W;

   localparam logic [ROT_ENTRY_W-1:0] ROT_ONE = ROT_ENTRY_W'(1) << ROT_FRAC_BITS;
   localparam logic [ROT_ENTRY_W-1:0] ROT_ZERO = '0;

   typedef enum logic [2:0] {
      KIND_MOTION     = 3'd0,
      KIND_INV_MOTION = 3'd1,
      KIND_FORCE      = 3'd2,
      KIND_INV_FORCE  = 3'd3,
      KIND_POINT      = 3'd4,
      KIND_INV_POINT  = 3'd5
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROT_ROW_0 = 3'd0,
      CSR_ROT_ROW_1 = 3'd1,
      CSR_ROT_ROW_2 = 3'd2,
      CSR_TRANS_X   = 3'd3,
      CSR_TRANS_Y   = 3'd4,
      CSR_TRANS_Z   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2:0]              kind;
      logic signed [VEC_W-1:0] in_top_x;
      logic signed [VEC_W-1:0] in_top_y;
      logic signed [VEC_W-1:0] in_top_z;
      logic signed [VEC_W-1:0] in_bottom_x;
      logic signed [VEC_W-1:0] in_bottom_y;
      logic signed [VEC_W-1:0] in_bottom_z;
   } req_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] out_top_x;
      logic signed [VEC_W-1:0] out_top_y;
      logic signed [VEC_W-1:0] out_top_z;
      logic signed [VEC_W-1:0] out_bottom_x;
      logic signed [VEC_W-1:0] out_bottom_y;
      logic signed [VEC_W-1:0] out_bottom_z;
      logic                    saturated;
   } rsp_type;

   // Per-item control decoded from kind, carried down the pipe
   typedef struct packed {
      logic live;     // a defined kind
      logic fwd;      // forward motion or force
      logic inv;      // inverse motion or force
      logic swap;     // force kinds: top and bottom trade places
      logic pt;       // point kinds
      logic pt_inv;   // inverse point
      logic tr;       // use the transposed rotation
   } ctl_type;

   // Clip to 32 signed bits; returns {clipped, value}
   function automatic logic [VEC_W:0] sat_vec(input logic signed [63:0] x);
      logic             clip;
      logic [VEC_W-1:0] val;
      clip = !((&x[63:VEC_W-1]) || !(|x[63:VEC_W-1]));
      if (!clip) begin
         val = x[VEC_W-1:0];
      end else if (x[63]) begin
         val = {1'b1, {(VEC_W-1){1'b0}}};
      end else begin
         val = {1'b0, {(VEC_W-1){1'b1}}};
      end
      return {clip, val};
   endfunction

   // Clip to 40 signed bits; returns {clipped, value}
   function automatic logic [MID_W:0] sat_mid(input logic signed [63:0] x);
      logic             clip;
      logic [MID_W-1:0] val;
      clip = !((&x[63:MID_W-1]) || !(|x[63:MID_W-1]));
      if (!clip) begin
         val = x[MID_W-1:0];
      end else if (x[63]) begin
         val = {1'b1, {(MID_W-1){1'b0}}};
      end else begin
         val = {1'b0, {(MID_W-1){1'b1}}};
      end
      return {clip, val};
   endfunction

endpackage

// File: hdl/spatial_vector_transform_unit.sv
// ----------------------------------------------------------------------------
// spatial_vector_transform_unit
// Each item passes through the pipeline registers of stages 1 to 7 to rsp_*.
// Throughput: one item per cycle unless rsp_ready stalls; seven pipeline
// registers, each with a valid bit, and a stage accepts new data whenever
// it is empty or drains onward.
// The long path per stage is one 32x32 or 18x40 multiply, or one wide add.
// Reset clears all valid bits, loads the identity rotation and zero translation.
// ----------------------------------------------------------------------------
module spatial_vector_transform_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  svt_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output svt_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [svt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [svt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import svt_pkg::*;

   localparam logic signed [S1_W-1:0] ROUND1 = S1_W'(1) << (ROT_FRAC_BITS - 1);
   localparam logic signed [S2_W-1:0] ROUND2 = S2_W'(1) << (ROT_FRAC_BITS - 1);
   localparam logic signed [XD_W-1:0] ROUNDX = XD_W'(1) << (VEC_FRAC_BITS - 1);

   // ---------------------------------------------------------------- config
   logic [ROT_ROW_W-1:0]    rot_row_ff [3];
   logic signed [VEC_W-1:0] trans_ff [3];
   logic signed [ROT_ENTRY_W-1:0] ent [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= {ROT_ZERO, ROT_ZERO, ROT_ONE};
         rot_row_ff[1] <= {ROT_ZERO, ROT_ONE, ROT_ZERO};
         rot_row_ff[2] <= {ROT_ONE, ROT_ZERO, ROT_ZERO};
         trans_ff[0]   <= '0;
         trans_ff[1]   <= '0;
         trans_ff[2]   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_ROW_0: rot_row_ff[0] <= csr_wdata;
            CSR_ROT_ROW_1: rot_row_ff[1] <= csr_wdata;
            CSR_ROT_ROW_2: rot_row_ff[2] <= csr_wdata;
            CSR_TRANS_X:   trans_ff[0]   <= csr_wdata[VEC_W-1:0];
            CSR_TRANS_Y:   trans_ff[1]   <= csr_wdata[VEC_W-1:0];
            CSR_TRANS_Z:   trans_ff[2]   <= csr_wdata[VEC_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ent[i][j] = rot_row_ff[i][j*ROT_ENTRY_W +: ROT_ENTRY_W];
         end
      end
   end

   // ------------------------------------------------------------ flow control
   logic [7:1] v_ff;
   logic [7:1] v_in;
   logic [7:1] en;

   always_comb begin
      en[7] = !v_ff[7] || rsp_ready;
      for (int k = 6; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in = v_ff;
      if (en[1]) begin
         v_in[1] = req_valid;
      end
      for (int k = 2; k <= 7; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[1];

   // ------------------------------------------------ stage 1: decode, select
   ctl_type                 s1_ctl_in, s1_ctl_ff;
   logic signed [X1_W-1:0]  s1_x1_in [3];
   logic signed [X1_W-1:0]  s1_x1_ff [3];
   logic signed [VEC_W-1:0] s1_a_in [3];
   logic signed [VEC_W-1:0] s1_a_ff [3];
   logic signed [VEC_W-1:0] s1_b_in [3];
   logic signed [VEC_W-1:0] s1_b_ff [3];
   logic signed [VEC_W-1:0] top [3];
   logic signed [VEC_W-1:0] bot [3];

   always_comb begin
      s1_ctl_in = '0;
      unique case (req_data.kind)
         KIND_MOTION:     begin s1_ctl_in.live = 1'b1; s1_ctl_in.fwd = 1'b1; end
         KIND_INV_MOTION: begin
            s1_ctl_in.live = 1'b1; s1_ctl_in.inv = 1'b1; s1_ctl_in.tr = 1'b1;
         end
         KIND_FORCE:      begin
            s1_ctl_in.live = 1'b1; s1_ctl_in.fwd = 1'b1; s1_ctl_in.swap = 1'b1;
         end
         KIND_INV_FORCE:  begin
            s1_ctl_in.live = 1'b1; s1_ctl_in.inv = 1'b1; s1_ctl_in.swap = 1'b1;
            s1_ctl_in.tr   = 1'b1;
         end
         KIND_POINT:      begin s1_ctl_in.live = 1'b1; s1_ctl_in.pt = 1'b1; end
         KIND_INV_POINT:  begin
            s1_ctl_in.live = 1'b1; s1_ctl_in.pt = 1'b1; s1_ctl_in.pt_inv = 1'b1;
            s1_ctl_in.tr   = 1'b1;
         end
         default: ;  // undefined kinds give an all-zero result
      endcase

      top[0] = req_data.in_top_x;
      top[1] = req_data.in_top_y;
      top[2] = req_data.in_top_z;
      bot[0] = req_data.in_bottom_x;
      bot[1] = req_data.in_bottom_y;
      bot[2] = req_data.in_bottom_z;

      for (int i = 0; i < 3; i++) begin
         s1_a_in[i] = s1_ctl_in.swap ? bot[i] : top[i];
         s1_b_in[i] = s1_ctl_in.swap ? top[i] : bot[i];
         if (s1_ctl_in.pt && !s1_ctl_in.pt_inv) begin
            s1_x1_in[i] = X1_W'(top[i]) - X1_W'(trans_ff[i]);
         end else begin
            s1_x1_in[i] = X1_W'(s1_a_in[i]);
         end
      end
   end

   // ----------------------------- stage 2: first rotation and r x a products
   ctl_type                s2_ctl_ff;
   logic signed [P1_W-1:0] s2_p1_in [3][3];
   logic signed [P1_W-1:0] s2_p1_ff [3][3];
   logic signed [XP_W-1:0] s2_xa_in [3];
   logic signed [XP_W-1:0] s2_xa_ff [3];
   logic signed [XP_W-1:0] s2_xb_in [3];
   logic signed [XP_W-1:0] s2_xb_ff [3];
   logic signed [VEC_W-1:0] s2_b_ff [3];
   logic signed [ROT_ENTRY_W-1:0] mat1 [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mat1[i][j]     = s1_ctl_ff.tr ? ent[j][i] : ent[i][j];
            s2_p1_in[i][j] = P1_W'(mat1[i][j]) * P1_W'(s1_x1_ff[j]);
         end
         s2_xa_in[i] = XP_W'(trans_ff[(i+1)%3]) * XP_W'(s1_a_ff[(i+2)%3]);
         s2_xb_in[i] = XP_W'(trans_ff[(i+2)%3]) * XP_W'(s1_a_ff[(i+1)%3]);
      end
   end

   // --------------------------------------------- stage 3: sum and round
   ctl_type                 s3_ctl_ff;
   logic signed [S1_W-1:0]  sum1 [3];
   logic signed [S1_W-1:0]  sh1 [3];
   logic signed [XD_W-1:0]  xd1 [3];
   logic signed [XD_W-1:0]  xs1 [3];
   logic signed [Y1_W-1:0]  s3_y1_in [3];
   logic signed [Y1_W-1:0]  s3_y1_ff [3];
   logic signed [C_W-1:0]   s3_c1_in [3];
   logic signed [C_W-1:0]   s3_c1_ff [3];
   logic signed [VEC_W-1:0] s3_b_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum1[i]     = S1_W'(s2_p1_ff[i][0]) + S1_W'(s2_p1_ff[i][1]) +
                       S1_W'(s2_p1_ff[i][2]) + ROUND1;
         sh1[i]      = sum1[i] >>> ROT_FRAC_BITS;
         s3_y1_in[i] = sh1[i][Y1_W-1:0];
         xd1[i]      = XD_W'(s2_xa_ff[i]) - XD_W'(s2_xb_ff[i]) + ROUNDX;
         xs1[i]      = xd1[i] >>> VEC_FRAC_BITS;
         s3_c1_in[i] = xs1[i][C_W-1:0];
      end
   end

   // ------------------------- stage 4: clip top triple, form b - r x a
   ctl_type                 s4_ctl_ff;
   logic signed [63:0]      rot_sum [3];
   logic signed [63:0]      diff [3];
   logic [VEC_W:0]          rot_sat [3];
   logic [MID_W:0]          d_sat [3];
   logic signed [VEC_W-1:0] s4_rot_in [3];
   logic signed [VEC_W-1:0] s4_rot_ff [3];
   logic signed [MID_W-1:0] s4_x2_in [3];
   logic signed [MID_W-1:0] s4_x2_ff [3];
   logic                    s4_flag_in, s4_flag_ff;

   always_comb begin
      s4_flag_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rot_sum[i] = 64'(s3_y1_ff[i]);
         if (s3_ctl_ff.pt_inv) begin
            rot_sum[i] = rot_sum[i] + 64'(trans_ff[i]);
         end
         rot_sat[i]   = sat_vec(rot_sum[i]);
         s4_rot_in[i] = rot_sat[i][VEC_W-1:0];
         diff[i]      = 64'(s3_b_ff[i]) - 64'(s3_c1_ff[i]);
         d_sat[i]     = sat_mid(diff[i]);
         if (s3_ctl_ff.fwd) begin
            s4_x2_in[i] = d_sat[i][MID_W-1:0];
         end else begin
            s4_x2_in[i] = MID_W'(s3_b_ff[i]);
         end
         s4_flag_in = s4_flag_in || rot_sat[i][VEC_W] ||
                      (s3_ctl_ff.fwd && d_sat[i][MID_W]);
      end
   end

   // --------------------------- stage 5: second rotation and r x top products
   ctl_type                 s5_ctl_ff;
   logic signed [P2_W-1:0]  s5_p2_in [3][3];
   logic signed [P2_W-1:0]  s5_p2_ff [3][3];
   logic signed [XP_W-1:0]  s5_xa_in [3];
   logic signed [XP_W-1:0]  s5_xa_ff [3];
   logic signed [XP_W-1:0]  s5_xb_in [3];
   logic signed [XP_W-1:0]  s5_xb_ff [3];
   logic signed [VEC_W-1:0] s5_rot_ff [3];
   logic                    s5_flag_ff;
   logic signed [ROT_ENTRY_W-1:0] mat2 [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mat2[i][j]     = s4_ctl_ff.tr ? ent[j][i] : ent[i][j];
            s5_p2_in[i][j] = P2_W'(mat2[i][j]) * P2_W'(s4_x2_ff[j]);
         end
         s5_xa_in[i] = XP_W'(trans_ff[(i+1)%3]) * XP_W'(s4_rot_ff[(i+2)%3]);
         s5_xb_in[i] = XP_W'(trans_ff[(i+2)%3]) * XP_W'(s4_rot_ff[(i+1)%3]);
      end
   end

   // --------------------------------------------- stage 6: sum and round
   ctl_type                 s6_ctl_ff;
   logic signed [S2_W-1:0]  sum2 [3];
   logic signed [S2_W-1:0]  sh2 [3];
   logic signed [XD_W-1:0]  xd2 [3];
   logic signed [XD_W-1:0]  xs2 [3];
   logic signed [Y2_W-1:0]  s6_y2_in [3];
   logic signed [Y2_W-1:0]  s6_y2_ff [3];
   logic signed [C_W-1:0]   s6_c2_in [3];
   logic signed [C_W-1:0]   s6_c2_ff [3];
   logic signed [VEC_W-1:0] s6_rot_ff [3];
   logic                    s6_flag_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum2[i]     = S2_W'(s5_p2_ff[i][0]) + S2_W'(s5_p2_ff[i][1]) +
                       S2_W'(s5_p2_ff[i][2]) + ROUND2;
         sh2[i]      = sum2[i] >>> ROT_FRAC_BITS;
         s6_y2_in[i] = sh2[i][Y2_W-1:0];
         xd2[i]      = XD_W'(s5_xa_ff[i]) - XD_W'(s5_xb_ff[i]) + ROUNDX;
         xs2[i]      = xd2[i] >>> VEC_FRAC_BITS;
         s6_c2_in[i] = xs2[i][C_W-1:0];
      end
   end

   // ------------------------------- stage 7: clip bottom triple, assemble
   logic signed [63:0]      lin_sum [3];
   logic [VEC_W:0]          lin_sat [3];
   logic signed [VEC_W-1:0] lin [3];
   logic signed [VEC_W-1:0] res_top [3];
   logic signed [VEC_W-1:0] res_bot [3];
   logic                    lin_flag;
   rsp_type                 rsp_in, rsp_ff;

   always_comb begin
      lin_flag = 1'b0;
      for (int i = 0; i < 3; i++) begin
         lin_sum[i] = 64'(s6_y2_ff[i]);
         if (s6_ctl_ff.inv) begin
            lin_sum[i] = lin_sum[i] + 64'(s6_c2_ff[i]);
         end
         lin_sat[i] = sat_vec(lin_sum[i]);
         lin[i]     = lin_sat[i][VEC_W-1:0];
         lin_flag   = lin_flag || lin_sat[i][VEC_W];
         if (s6_ctl_ff.pt) begin
            res_top[i] = s6_rot_ff[i];
            res_bot[i] = '0;
         end else if (s6_ctl_ff.swap) begin
            res_top[i] = lin[i];
            res_bot[i] = s6_rot_ff[i];
         end else begin
            res_top[i] = s6_rot_ff[i];
            res_bot[i] = lin[i];
         end
      end

      rsp_in = '0;
      if (s6_ctl_ff.live) begin
         rsp_in.out_top_x    = res_top[0];
         rsp_in.out_top_y    = res_top[1];
         rsp_in.out_top_z    = res_top[2];
         rsp_in.out_bottom_x = res_bot[0];
         rsp_in.out_bottom_y = res_bot[1];
         rsp_in.out_bottom_z = res_bot[2];
         rsp_in.saturated    = s6_flag_ff || (!s6_ctl_ff.pt && lin_flag);
      end
   end

   // -------------------------------------------------------- data registers
   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_ctl_ff <= s1_ctl_in;
         s1_x1_ff  <= s1_x1_in;
         s1_a_ff   <= s1_a_in;
         s1_b_ff   <= s1_b_in;
      end
      if (en[2]) begin
         s2_ctl_ff <= s1_ctl_ff;
         s2_p1_ff  <= s2_p1_in;
         s2_xa_ff  <= s2_xa_in;
         s2_xb_ff  <= s2_xb_in;
         s2_b_ff   <= s1_b_ff;
      end
      if (en[3]) begin
         s3_ctl_ff <= s2_ctl_ff;
         s3_y1_ff  <= s3_y1_in;
         s3_c1_ff  <= s3_c1_in;
         s3_b_ff   <= s2_b_ff;
      end
      if (en[4]) begin
         s4_ctl_ff  <= s3_ctl_ff;
         s4_rot_ff  <= s4_rot_in;
         s4_x2_ff   <= s4_x2_in;
         s4_flag_ff <= s4_flag_in;
      end
      if (en[5]) begin
         s5_ctl_ff  <= s4_ctl_ff;
         s5_p2_ff   <= s5_p2_in;
         s5_xa_ff   <= s5_xa_in;
         s5_xb_ff   <= s5_xb_in;
         s5_rot_ff  <= s4_rot_ff;
         s5_flag_ff <= s4_flag_ff;
      end
      if (en[6]) begin
         s6_ctl_ff  <= s5_ctl_ff;
         s6_y2_ff   <= s6_y2_in;
         s6_c2_ff   <= s6_c2_in;
         s6_rot_ff  <= s5_rot_ff;
         s6_flag_ff <= s5_flag_ff;
      end
      if (en[7]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v_ff[7];
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // An empty output stage lets the whole pipe advance
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !v_ff[7] |-> req_ready)
      else $error("input stalled while output stage is empty");

   // Undefined kinds leave nothing but zeros
   a_dead_kind_zero: assert property (@(posedge clock) disable iff (reset)
      v_ff[6] && !s6_ctl_ff.live |-> rsp_in == '0)
      else $error("undefined kind produced a nonzero result");

   // Point kinds clear the bottom triple
   a_point_bottom_zero: assert property (@(posedge clock) disable iff (reset)
      v_ff[6] && s6_ctl_ff.pt |->
         rsp_in.out_bottom_x == '0 && rsp_in.out_bottom_y == '0 &&
         rsp_in.out_bottom_z == '0)
      else $error("point result with nonzero bottom triple");

   // A blocked mid-pipe stage keeps its item
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] && !en[3] |=> v_ff[3] && $stable(s3_c1_ff[0]) && $stable(s3_y1_ff[0]))
      else $error("stalled item lost or changed in stage 3");
`endif

endmodule
